// ===== src/rsd_pkg.sv =====
// Shared types and constants for the row standard deviation block.
`timescale 1ns / 1ps

package rsd_pkg;

	localparam int DEF_MAX_COLUMNS  = 1024;
	localparam int DEF_SAMPLE_WIDTH = 16;

	localparam int CFG_W   = 11;   // row_length register width
	localparam int LEN_W   = 17;   // effective row length, holds up to 65536
	localparam int SUM_W   = 48;   // squared-difference accumulator
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 1;
	localparam int STEP_W  = $clog2(SUM_W);
	localparam int DEV_W   = 16;
	localparam int SQ_IN_W = 24;   // magnitudes at or above 2^24 saturate the square

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

	// One finished row waiting for the divide and square root.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [LEN_W-1:0] len;
	} rsd_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_DONE
	} rsd_back_state_t;

endpackage

// ===== src/rsd_front.sv =====
// Front end: sample intake, squared difference and row accumulation.
`timescale 1ns / 1ps

module rsd_front #(
	parameter int MAX_COLUMNS  = rsd_pkg::DEF_MAX_COLUMNS,
	parameter int SAMPLE_WIDTH = rsd_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          row_length_we,
	input  logic [rsd_pkg::CFG_W-1:0]     row_length,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_WIDTH-1:0]       sample,
	input  logic [SAMPLE_WIDTH-1:0]       row_mean,
	output logic                          push,
	output rsd_pkg::rsd_entry_t           push_data,
	input  logic                          q_full
);
	import rsd_pkg::*;

	localparam int MW    = SAMPLE_WIDTH + 1;
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

	logic [CFG_W-1:0]   row_length_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_inc;
	logic [LEN_W-1:0]   len_eff;
	logic               adv;
	logic               accept;
	logic               last_in;
	logic [MW-1:0]      diff;
	logic [MW-1:0]      mag;
	logic               big;

	logic               v_s1;
	logic               last_s1;
	logic               big_s1;
	logic [SQ_IN_W-1:0] m_s1;
	logic               v_s2;
	logic               last_s2;
	logic [SUM_W-1:0]   sq_s2;

	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   total;

	// Zero length acts as one, lengths past the column limit clamp to it.
	always_comb begin
		if (row_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(row_length_q) > 32'(MAX_COLUMNS)) begin
			len_eff = LEN_W'(MAX_COLUMNS);
		end else begin
			len_eff = LEN_W'(row_length_q);
		end
	end

	// Hold the whole front only when a row end meets a full queue.
	assign adv      = !(v_s2 && last_s2 && q_full);
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign last_in = LEN_W'(cnt_inc) >= len_eff;

	assign diff = {sample[SAMPLE_WIDTH-1], sample} - {row_mean[SAMPLE_WIDTH-1], row_mean};
	assign mag  = diff[MW-1] ? (~diff + MW'(1)) : diff;
	assign big  = (34'(mag) >> SQ_IN_W) != 34'(0);

	assign sum_wide = {1'b0, sum_q} + {1'b0, sq_s2};
	assign total    = (sum_wide >= {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

	assign push           = v_s2 && last_s2 && adv;
	assign push_data.sum  = total;
	assign push_data.len  = len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= CFG_W'(1);
			cnt_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			sum_q        <= '0;
		end else begin
			if (row_length_we) begin
				row_length_q <= row_length;
			end
			if (accept) begin
				cnt_q <= last_in ? '0 : cnt_inc;
			end
			if (adv) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
				if (v_s2) begin
					sum_q <= last_s2 ? '0 : total;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last_in;
			big_s1  <= big;
			m_s1    <= SQ_IN_W'(34'(mag));
			last_s2 <= last_s1;
			sq_s2   <= big_s1 ? SUM_MAX : (SUM_W'(m_s1) * SUM_W'(m_s1));
		end
	end

endmodule

// ===== src/rsd_fifo.sv =====
// Two-entry queue of finished row sums between front and back end.
`timescale 1ns / 1ps

module rsd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rsd_pkg::rsd_entry_t push_data,
	input  logic                pop,
	output rsd_pkg::rsd_entry_t pop_data,
	output logic                full,
	output logic                empty
);
	import rsd_pkg::*;

	rsd_entry_t        entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = entries[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/rsd_back.sv =====
// Back end: bit-serial divide by row length, then digit-serial square root.
`timescale 1ns / 1ps

module rsd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  rsd_pkg::rsd_entry_t           q_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rsd_pkg::DEV_W-1:0]     deviation
);
	import rsd_pkg::*;

	rsd_back_state_t   state_q;
	rsd_back_state_t   state_d;
	logic              div_en;
	logic              sqrt_en;
	logic              load_out;
	logic              last_div;
	logic              last_sqrt;

	logic [SUM_W-1:0]  dq_q;      // dividend shifting out, quotient shifting in
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [LEN_W-1:0]  len_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [DEV_W-1:0]  deviation_q;

	logic [LEN_W:0]    div_sh;
	logic              div_ge;
	logic [LEN_W:0]    div_rem;
	logic [REM_W+1:0]  sq_sh;
	logic [REM_W+1:0]  sq_trial;
	logic              sq_ge;
	logic [REM_W+1:0]  sq_rem;

	assign last_div  = step_q == STEP_W'(SUM_W - 1);
	assign last_sqrt = step_q == STEP_W'(ROOT_W - 1);

	// One quotient bit per cycle.
	assign div_sh  = {rem_q[LEN_W-1:0], dq_q[SUM_W-1]};
	assign div_ge  = div_sh >= {1'b0, len_q};
	assign div_rem = div_ge ? (div_sh - {1'b0, len_q}) : div_sh;

	// One root bit per cycle from two bits of the quotient.
	assign sq_sh    = {rem_q, dq_q[SUM_W-1 -: 2]};
	assign sq_trial = (REM_W+2)'({root_q, 2'b01});
	assign sq_ge    = sq_sh >= sq_trial;
	assign sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		div_en   = 1'b0;
		sqrt_en  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				div_en = 1'b1;
				if (last_div) begin
					state_d = BK_SQRT;
				end
			end
			BK_SQRT: begin
				sqrt_en = 1'b1;
				if (last_sqrt) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dq_q   <= q_data.sum;
			len_q  <= q_data.len;
			rem_q  <= '0;
			step_q <= '0;
		end else if (div_en) begin
			dq_q <= {dq_q[SUM_W-2:0], div_ge};
			if (last_div) begin
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
			end else begin
				rem_q  <= REM_W'(div_rem[LEN_W-1:0]);
				step_q <= step_q + STEP_W'(1);
			end
		end else if (sqrt_en) begin
			dq_q   <= {dq_q[SUM_W-3:0], 2'b00};
			rem_q  <= sq_rem[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], sq_ge};
			step_q <= step_q + STEP_W'(1);
		end
		if (load_out) begin
			deviation_q <= (root_q > ROOT_W'(DEV_MAX)) ? DEV_MAX : root_q[DEV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign deviation = deviation_q;

endmodule

// ===== src/row_standard_deviation.sv =====
// Row standard deviation top level: front end, row queue and back end.
// Path of a row's result after its last beat is accepted:
//   2 front stages into the queue, 1 queue pop, 48 divide steps, 24 root steps, 1 output load.
// Throughput: one sample beat per cycle; the back end takes one row at a time from the queue,
//   so rows that arrive faster than it finishes them stall the input once both queue entries are full.
// Reset: arst_n clears the accumulator, column count, queue and out_valid; row_length reads 1.
`timescale 1ns / 1ps

module row_standard_deviation #(
	parameter int MAX_COLUMNS  = rsd_pkg::DEF_MAX_COLUMNS,
	parameter int SAMPLE_WIDTH = rsd_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      row_length_we,
	input  logic [rsd_pkg::CFG_W-1:0] row_length,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_WIDTH-1:0]   sample,
	input  logic [SAMPLE_WIDTH-1:0]   row_mean,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rsd_pkg::DEV_W-1:0] deviation
);
	import rsd_pkg::*;

	// Queue handshake between the two halves.
	logic       push;
	rsd_entry_t push_data;
	logic       pop;
	rsd_entry_t pop_data;
	logic       q_full;
	logic       q_empty;

	// Front end: take one beat per cycle unless a full queue stalls it, square the
	// difference from the row mean, accumulate, and hand the finished row sum and length to the queue.
	rsd_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_length_we(row_length_we),
		.row_length   (row_length),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.row_mean     (row_mean),
		.push         (push),
		.push_data    (push_data),
		.q_full       (q_full)
	);

	// Short queue so accumulation of the next rows continues while the back
	// end is still dividing.
	rsd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back end: floor(sum / length), then floor square root, saturate to 16 bits,
	// and hold the result in the output register until taken.
	rsd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.deviation(deviation)
	);

	// The front must never push into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && q_full))
		else $error("row sum pushed into full queue");

	// The back end must never pop an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && q_empty))
		else $error("row sum popped from empty queue");

	// Input stalls only while the queue is full.
	assert property (@(posedge clk) disable iff (!arst_n) !in_ready |-> q_full)
		else $error("input stalled with room in queue");

endmodule
